>>> sv/vector3_fixed_point_alu_top_assert.svh
// Assertion macros used by the vector ALU back pipeline (v3alu_back).
// Both expect a signal named clock in the calling scope; V3A_ASSERT also expects reset.
`ifndef VECTOR3_FIXED_POINT_ALU_TOP_ASSERT_SVH
`define VECTOR3_FIXED_POINT_ALU_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define V3A_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("v3alu assertion failed");
`define V3A_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("v3alu assertion failed");
`else
`define V3A_ASSERT(lbl, prop)
`define V3A_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/v3alu_pkg.sv
package v3alu_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int QUO_W      = FRAC_BITS + 1;
   localparam int DIV_STEPS  = FRAC_BITS + 1;
   localparam int NUM_W      = FRAC_BITS + 33;
   localparam int SQRT_STEPS = 32;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      CODE_ADD     = 3'd0,
      CODE_SUB     = 3'd1,
      CODE_MUL     = 3'd2,
      CODE_SCALE   = 3'd3,
      CODE_DOT     = 3'd4,
      CODE_CROSS   = 3'd5,
      CODE_NORM    = 3'd6,
      CODE_REFLECT = 3'd7
   } code_type;

   typedef enum logic [7:0] {
      OP_ADD     = 8'b0000_0001,
      OP_SUB     = 8'b0000_0010,
      OP_MUL     = 8'b0000_0100,
      OP_SCALE   = 8'b0000_1000,
      OP_DOT     = 8'b0001_0000,
      OP_CROSS   = 8'b0010_0000,
      OP_NORM    = 8'b0100_0000,
      OP_REFLECT = 8'b1000_0000
   } op_type;

   typedef logic [2:0][31:0] vec_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] scale;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic signed [31:0] scalar_out;
      logic [30:0]        length;
      logic               overflow;
      logic               zero_length;
   } rsp_item_type;

   // item as it sits in the queue: decoded op plus the raw request
   typedef struct packed {
      op_type       op;
      req_item_type item;
   } fe_item_type;

   // per-item state carried down the back pipeline
   typedef struct packed {
      op_type      op;
      vec_type     a;
      vec_type     b;
      vec_type     r;
      logic [31:0] scalar;
      logic [31:0] d;
      logic        ov;
      logic        zl;
   } carry_type;

   function automatic op_type decode_op(input logic [2:0] code);
      op_type op;
      case (code)
         CODE_ADD:     op = OP_ADD;
         CODE_SUB:     op = OP_SUB;
         CODE_MUL:     op = OP_MUL;
         CODE_SCALE:   op = OP_SCALE;
         CODE_DOT:     op = OP_DOT;
         CODE_CROSS:   op = OP_CROSS;
         CODE_NORM:    op = OP_NORM;
         CODE_REFLECT: op = OP_REFLECT;
         default:      op = OP_ADD;
      endcase
      return op;
   endfunction

   // {overflow, value} clamped to the 32-bit signed range
   function automatic logic [32:0] sat32(input logic signed [66:0] v);
      logic [32:0] res;
      if (v > 67'sd2147483647) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -67'sd2147483648) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

   // drop the fraction bits, round half toward +inf
   function automatic logic signed [66:0] round_shift(input logic signed [66:0] v);
      logic signed [66:0] t;
      t = v + (67'sd1 <<< (FRAC_BITS - 1));
      return t >>> FRAC_BITS;
   endfunction

endpackage

>>> sv/v3alu_fifo.sv
module v3alu_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  v3alu_pkg::fe_item_type push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output v3alu_pkg::fe_item_type head
);

   v3alu_pkg::fe_item_type mem_ff [v3alu_pkg::FIFO_DEPTH];
   logic [v3alu_pkg::FIFO_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [v3alu_pkg::FIFO_AW:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (v3alu_pkg::FIFO_AW + 1)'(v3alu_pkg::FIFO_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (v3alu_pkg::FIFO_AW + 1)'(push) - (v3alu_pkg::FIFO_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

>>> sv/v3alu_front.sv
module v3alu_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  v3alu_pkg::req_item_type req_data,
   input  logic                    full,
   output logic                    push,
   output v3alu_pkg::fe_item_type  push_item
);

   logic                   valid_ff, valid_in;
   v3alu_pkg::fe_item_type item_ff, item_in;
   logic                   take;

   // holding register only blocks when the queue cannot take its item
   assign req_stall = valid_ff && full;
   assign take      = req_valid && !req_stall;
   assign push      = valid_ff && !full;
   assign push_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in     = 1'b1;
         item_in.op   = v3alu_pkg::decode_op(req_data.req_type);
         item_in.item = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

>>> sv/v3alu_isqrt.sv
module v3alu_isqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [63:0]          s_in,
   input  v3alu_pkg::carry_type c_in,
   output logic                 out_valid,
   output logic [31:0]          root,
   output v3alu_pkg::carry_type c_out
);

   // one result bit per stage, rounding in a last stage
   logic [63:0]          s_ff [v3alu_pkg::SQRT_STEPS];
   logic [63:0]          r_ff [v3alu_pkg::SQRT_STEPS];
   v3alu_pkg::carry_type c_ff [v3alu_pkg::SQRT_STEPS];
   logic                 v_ff [v3alu_pkg::SQRT_STEPS];

   logic [31:0]          root_ff, root_in;
   v3alu_pkg::carry_type cout_ff;
   logic                 vout_ff;

   for (genvar k = 0; k < v3alu_pkg::SQRT_STEPS; k++) begin : g_step
      logic [63:0]          s_prev, r_prev, s_next, r_next, bitv;
      logic [64:0]          trial;
      v3alu_pkg::carry_type c_prev;
      logic                 v_prev;

      if (k == 0) begin : g_first
         assign s_prev = s_in;
         assign r_prev = '0;
         assign c_prev = c_in;
         assign v_prev = in_valid;
      end else begin : g_next
         assign s_prev = s_ff[k-1];
         assign r_prev = r_ff[k-1];
         assign c_prev = c_ff[k-1];
         assign v_prev = v_ff[k-1];
      end

      assign bitv = 64'd1 << (62 - 2 * k);

      always_comb begin
         trial = {1'b0, r_prev} + {1'b0, bitv};
         if ({1'b0, s_prev} >= trial) begin
            s_next = s_prev - trial[63:0];
            r_next = (r_prev >> 1) + bitv;
         end else begin
            s_next = s_prev;
            r_next = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
         if (en) begin
            s_ff[k] <= s_next;
            r_ff[k] <= r_next;
            c_ff[k] <= c_prev;
         end
      end
   end

   // remainder above root means the true root is past the half point
   always_comb begin
      if (s_ff[v3alu_pkg::SQRT_STEPS-1] > r_ff[v3alu_pkg::SQRT_STEPS-1]) begin
         root_in = r_ff[v3alu_pkg::SQRT_STEPS-1][31:0] + 32'd1;
      end else begin
         root_in = r_ff[v3alu_pkg::SQRT_STEPS-1][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en) begin
         vout_ff <= v_ff[v3alu_pkg::SQRT_STEPS-1];
      end
      if (en) begin
         root_ff <= root_in;
         cout_ff <= c_ff[v3alu_pkg::SQRT_STEPS-1];
      end
   end

   assign out_valid = vout_ff;
   assign root      = root_ff;
   assign c_out     = cout_ff;

endmodule

>>> sv/v3alu_back.sv
`include "vector3_fixed_point_alu_top_assert.svh"
module v3alu_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  v3alu_pkg::fe_item_type  q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output v3alu_pkg::rsp_item_type rsp_data
);

   logic adv;

   // stage 1: products
   logic signed [63:0]   p_ff [3], q_ff [3], p_in [3], q_in [3];
   v3alu_pkg::carry_type c1_ff, c1_in;
   logic                 v1_ff;
   // stage 2: exact sums, add/sub
   logic signed [66:0]   e_ff [3], e_in [3], dsum_ff, dsum_in;
   v3alu_pkg::carry_type c2_ff, c2_in;
   logic                 v2_ff;
   // stage 3: round and saturate
   v3alu_pkg::carry_type c3_ff, c3_in;
   logic [63:0]          s3_ff;
   logic                 v3_ff;
   // first root: length of a for normalize
   logic                 vl;
   logic [31:0]          len_l;
   v3alu_pkg::carry_type cl;
   // divide prep
   logic [2:0][v3alu_pkg::NUM_W-1:0] rem0_ff, rem0_in;
   logic [31:0]          dl0_ff;
   v3alu_pkg::carry_type cdp_ff, cdp_in;
   logic                 vdp_ff;
   // divide steps
   logic [2:0][v3alu_pkg::NUM_W-1:0] rem_ff [v3alu_pkg::DIV_STEPS];
   logic [2:0][v3alu_pkg::QUO_W-1:0] quo_ff [v3alu_pkg::DIV_STEPS];
   logic [31:0]          dl_ff [v3alu_pkg::DIV_STEPS];
   v3alu_pkg::carry_type cd_ff [v3alu_pkg::DIV_STEPS];
   logic                 vd_ff [v3alu_pkg::DIV_STEPS];
   // normalize finish
   v3alu_pkg::carry_type cnf_ff, cnf_in;
   logic                 vnf_ff;
   // reflect
   logic signed [63:0]   tp_ff [3], tp_in [3];
   v3alu_pkg::carry_type c4_ff;
   logic                 v4_ff;
   logic [31:0]          t_ff [3], t_in [3];
   v3alu_pkg::carry_type c5_ff, c5_in;
   logic                 v5_ff;
   v3alu_pkg::carry_type c6_ff, c6_in;
   logic                 v6_ff;
   // result length
   logic [63:0]          sq_ff [3], sq_in [3];
   v3alu_pkg::carry_type c7_ff;
   logic                 v7_ff;
   logic [63:0]          s8_ff, s8_in;
   v3alu_pkg::carry_type c8_ff;
   logic                 v8_ff;
   logic                 vf;
   logic [31:0]          len_f;
   v3alu_pkg::carry_type cf;
   // output
   logic                    rsp_valid_ff;
   v3alu_pkg::rsp_item_type rsp_data_ff, rsp_in;
   logic                    rsp_zero_clean;

   // whole pipeline moves together; output slot frees it
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && !q_empty;

   // ---------------- stage 1
   always_comb begin
      v3alu_pkg::vec_type av, bv;
      logic signed [31:0] mx, my, nx, ny;
      int j, k;
      av = {q_head.item.a_z, q_head.item.a_y, q_head.item.a_x};
      bv = {q_head.item.b_z, q_head.item.b_y, q_head.item.b_x};
      c1_in        = '0;
      c1_in.op     = q_head.op;
      c1_in.a      = av;
      c1_in.b      = bv;
      for (int i = 0; i < 3; i++) begin
         j = (i == 2) ? 0 : i + 1;
         k = (i == 0) ? 2 : i - 1;
         nx = av[k];
         ny = bv[j];
         case (q_head.op)
            v3alu_pkg::OP_CROSS: begin
               mx = av[j];
               my = bv[k];
            end
            v3alu_pkg::OP_SCALE: begin
               mx = av[i];
               my = q_head.item.scale;
            end
            v3alu_pkg::OP_NORM: begin
               mx = av[i];
               my = av[i];
            end
            default: begin
               mx = av[i];
               my = bv[i];
            end
         endcase
         p_in[i] = 64'(mx) * 64'(my);
         q_in[i] = 64'(nx) * 64'(ny);
      end
   end

   // ---------------- stage 2
   always_comb begin
      logic signed [66:0] sum;
      logic [32:0]        sv;
      c2_in   = c1_ff;
      dsum_in = 67'(p_ff[0]) + 67'(p_ff[1]) + 67'(p_ff[2]);
      for (int i = 0; i < 3; i++) begin
         if (c1_ff.op == v3alu_pkg::OP_CROSS) begin
            e_in[i] = 67'(p_ff[i]) - 67'(q_ff[i]);
         end else begin
            e_in[i] = 67'(p_ff[i]);
         end
         if (c1_ff.op == v3alu_pkg::OP_SUB) begin
            sum = 67'(signed'(c1_ff.a[i])) - 67'(signed'(c1_ff.b[i]));
         end else begin
            sum = 67'(signed'(c1_ff.a[i])) + 67'(signed'(c1_ff.b[i]));
         end
         sv = v3alu_pkg::sat32(sum);
         if (c1_ff.op == v3alu_pkg::OP_ADD || c1_ff.op == v3alu_pkg::OP_SUB) begin
            c2_in.r[i] = sv[31:0];
            c2_in.ov   = c2_in.ov | sv[32];
         end
      end
   end

   // ---------------- stage 3
   always_comb begin
      logic [32:0] rs, ds;
      c3_in = c2_ff;
      for (int i = 0; i < 3; i++) begin
         rs = v3alu_pkg::sat32(v3alu_pkg::round_shift(e_ff[i]));
         if (c2_ff.op == v3alu_pkg::OP_MUL || c2_ff.op == v3alu_pkg::OP_SCALE ||
             c2_ff.op == v3alu_pkg::OP_CROSS) begin
            c3_in.r[i] = rs[31:0];
            c3_in.ov   = c3_in.ov | rs[32];
         end
      end
      ds = v3alu_pkg::sat32(v3alu_pkg::round_shift(dsum_ff));
      if (c2_ff.op == v3alu_pkg::OP_DOT) begin
         c3_in.scalar = ds[31:0];
         c3_in.ov     = c3_in.ov | ds[32];
      end
      if (c2_ff.op == v3alu_pkg::OP_REFLECT) begin
         c3_in.d  = ds[31:0];
         c3_in.ov = c3_in.ov | ds[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= p_in[i];
            q_ff[i] <= q_in[i];
            e_ff[i] <= e_in[i];
         end
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         dsum_ff <= dsum_in;
         c3_ff   <= c3_in;
         s3_ff   <= dsum_ff[63:0];
      end
   end

   // ---------------- |a| for normalize
   v3alu_isqrt u_len_a (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (v3_ff),
      .s_in     (s3_ff),
      .c_in     (c3_ff),
      .out_valid(vl),
      .root     (len_l),
      .c_out    (cl)
   );

   // ---------------- divide prep: numerator plus half divisor for rounding
   always_comb begin
      logic [31:0] mag;
      cdp_in = cl;
      for (int i = 0; i < 3; i++) begin
         mag        = cl.a[i][31] ? (~cl.a[i] + 32'd1) : cl.a[i];
         rem0_in[i] = (v3alu_pkg::NUM_W'(mag) << v3alu_pkg::FRAC_BITS) +
                      v3alu_pkg::NUM_W'(len_l >> 1);
      end
      if (cl.op == v3alu_pkg::OP_NORM && len_l == '0) begin
         cdp_in.zl = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vdp_ff <= 1'b0;
      end else if (adv) begin
         vdp_ff <= vl;
      end
      if (adv) begin
         rem0_ff <= rem0_in;
         dl0_ff  <= len_l;
         cdp_ff  <= cdp_in;
      end
   end

   // ---------------- restoring divide, one quotient bit per stage
   for (genvar m = 0; m < v3alu_pkg::DIV_STEPS; m++) begin : g_div
      logic [2:0][v3alu_pkg::NUM_W-1:0] rem_prev, rem_next;
      logic [2:0][v3alu_pkg::QUO_W-1:0] quo_prev, quo_next;
      logic [31:0]                      dl_prev;
      v3alu_pkg::carry_type             c_prev;
      logic                             v_prev;
      logic [v3alu_pkg::NUM_W-1:0]      dsh;

      if (m == 0) begin : g_first
         assign rem_prev = rem0_ff;
         assign quo_prev = '0;
         assign dl_prev  = dl0_ff;
         assign c_prev   = cdp_ff;
         assign v_prev   = vdp_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[m-1];
         assign quo_prev = quo_ff[m-1];
         assign dl_prev  = dl_ff[m-1];
         assign c_prev   = cd_ff[m-1];
         assign v_prev   = vd_ff[m-1];
      end

      assign dsh = v3alu_pkg::NUM_W'(dl_prev) << (v3alu_pkg::FRAC_BITS - m);

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (rem_prev[i] >= dsh) begin
               rem_next[i] = rem_prev[i] - dsh;
               quo_next[i] = quo_prev[i] |
                             (v3alu_pkg::QUO_W'(1) << (v3alu_pkg::FRAC_BITS - m));
            end else begin
               rem_next[i] = rem_prev[i];
               quo_next[i] = quo_prev[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[m] <= 1'b0;
         end else if (adv) begin
            vd_ff[m] <= v_prev;
         end
         if (adv) begin
            rem_ff[m] <= rem_next;
            quo_ff[m] <= quo_next;
            dl_ff[m]  <= dl_prev;
            cd_ff[m]  <= c_prev;
         end
      end
   end

   // ---------------- normalize finish: restore sign
   always_comb begin
      logic [31:0] qv;
      cnf_in = cd_ff[v3alu_pkg::DIV_STEPS-1];
      for (int i = 0; i < 3; i++) begin
         qv = 32'(quo_ff[v3alu_pkg::DIV_STEPS-1][i]);
         if (cnf_in.op == v3alu_pkg::OP_NORM && !cnf_in.zl) begin
            cnf_in.r[i] = cnf_in.a[i][31] ? (32'd0 - qv) : qv;
         end
      end
   end

   // ---------------- reflect: d*b, round, double, minus a
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tp_in[i] = 64'(signed'(cnf_ff.d)) * 64'(signed'(cnf_ff.b[i]));
      end
   end

   always_comb begin
      logic [32:0] ts;
      c5_in = c4_ff;
      for (int i = 0; i < 3; i++) begin
         ts      = v3alu_pkg::sat32(v3alu_pkg::round_shift(67'(tp_ff[i])));
         t_in[i] = ts[31:0];
         if (c4_ff.op == v3alu_pkg::OP_REFLECT) begin
            c5_in.ov = c5_in.ov | ts[32];
         end
      end
   end

   always_comb begin
      logic signed [66:0] tt;
      logic [32:0]        us, rs;
      c6_in = c5_ff;
      for (int i = 0; i < 3; i++) begin
         tt = 67'(signed'(t_ff[i]));
         us = v3alu_pkg::sat32(tt + tt);
         rs = v3alu_pkg::sat32(67'(signed'(us[31:0])) - 67'(signed'(c5_ff.a[i])));
         if (c5_ff.op == v3alu_pkg::OP_REFLECT) begin
            c6_in.r[i] = rs[31:0];
            c6_in.ov   = c6_in.ov | us[32] | rs[32];
         end
      end
   end

   // ---------------- squares of the result for its length
   always_comb begin
      logic signed [63:0] sp;
      for (int i = 0; i < 3; i++) begin
         sp       = 64'(signed'(c6_ff.r[i])) * 64'(signed'(c6_ff.r[i]));
         sq_in[i] = sp;
      end
      s8_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vnf_ff <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
      end else if (adv) begin
         vnf_ff <= vd_ff[v3alu_pkg::DIV_STEPS-1];
         v4_ff  <= vnf_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
      end
      if (adv) begin
         cnf_ff <= cnf_in;
         c4_ff  <= cnf_ff;
         c5_ff  <= c5_in;
         c6_ff  <= c6_in;
         c7_ff  <= c6_ff;
         c8_ff  <= c7_ff;
         s8_ff  <= s8_in;
         for (int i = 0; i < 3; i++) begin
            tp_ff[i] <= tp_in[i];
            t_ff[i]  <= t_in[i];
            sq_ff[i] <= sq_in[i];
         end
      end
   end

   v3alu_isqrt u_len_r (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (v8_ff),
      .s_in     (s8_ff),
      .c_in     (c8_ff),
      .out_valid(vf),
      .root     (len_f),
      .c_out    (cf)
   );

   // ---------------- output register
   always_comb begin
      logic len_big;
      len_big            = len_f > 32'(v3alu_pkg::LEN_MAX);
      rsp_in.r_x         = cf.r[0];
      rsp_in.r_y         = cf.r[1];
      rsp_in.r_z         = cf.r[2];
      rsp_in.scalar_out  = cf.scalar;
      rsp_in.length      = len_big ? v3alu_pkg::LEN_MAX : len_f[30:0];
      rsp_in.overflow    = cf.ov | len_big;
      rsp_in.zero_length = cf.zl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vf;
      end
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // zero vector, zero length, no overflow
   assign rsp_zero_clean = rsp_data_ff.r_x == 32'sd0 && rsp_data_ff.r_y == 32'sd0 &&
                           rsp_data_ff.r_z == 32'sd0 && rsp_data_ff.length == 31'd0 &&
                           !rsp_data_ff.overflow;

   `V3A_ASSERT(a_zero_len_clean, rsp_valid_ff && rsp_data_ff.zero_length |-> rsp_zero_clean)
   `V3A_ASSERT(a_pop_nonempty, q_pop |-> !q_empty)
   `V3A_ASSERT(a_pop_enters, q_pop |=> v1_ff)
   `V3A_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid_ff && !v1_ff)

endmodule

>>> sv/vector3_fixed_point_alu_top.sv
// Vector and scalar values are signed Q16.16 fixed point (FRAC_BITS = 16).
// Throughput: one item per cycle; the back pipeline moves whenever the output is free.
// Two 33-stage square-root pipes and a FRAC_BITS+1 stage divider set the depth.
// Reset: synchronous, active high; clears all valid bits and the queue, drops items in flight.
module vector3_fixed_point_alu_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  v3alu_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output v3alu_pkg::rsp_item_type rsp_data
);

   // front -> queue
   logic                   push, full;
   v3alu_pkg::fe_item_type push_item;
   // queue -> back
   logic                   pop, empty;
   v3alu_pkg::fe_item_type head;

   // front: one holding register, decodes the op code to one-hot
   v3alu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .full     (full),
      .push     (push),
      .push_item(push_item)
   );

   // short queue so a stalled output does not stall intake right away
   v3alu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   // back: multiply, sum, round, root, divide, reflect, length
   v3alu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (empty),
      .q_head   (head),
      .q_pop    (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
